>>> sv/trsp_pkg.sv
// ----------------------------------------------------------------------------
// trsp_pkg: shared types and constants of the tree relay PWM block
// Command codes, phase encoding, register indexes and the result record
// handed from the step logic to the output stage.
// ----------------------------------------------------------------------------
package trsp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0]    MsgTimeoutRst = 8'd10;
  localparam logic [ElapsedW-1:0] ShutoffRst    = 16'd1000;
  localparam logic [ByteW-1:0]    SlewRateRst   = 8'd255;
  localparam logic [ElapsedW-1:0] ElapsedMax    = 16'hFFFF;

  // input item kinds
  typedef enum logic [CmdW-1:0] {
    CMD_BYTE = 2'd0,
    CMD_MS   = 2'd1,
    CMD_PWM  = 2'd2
  } cmd_e;

  // command bytes seen in the idle phase
  typedef enum logic [ByteW-1:0] {
    BCMD_ZERO = 8'h00,
    BCMD_SET  = 8'h01,
    BCMD_RAMP = 8'h02
  } bcmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MSG_TIMEOUT = 2'd0,
    REG_SHUTOFF     = 2'd1
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_SETPOINT = 4'b0010,
    PH_FORWARD  = 4'b0100,
    PH_RAMP     = 4'b1000
  } phase_e;

  // everything one input item produces; dual marks an echo to both ports
  typedef struct packed {
    logic             tx_valid;
    logic             tx_port;
    logic [ByteW-1:0] tx_byte;
    logic [ByteW-1:0] duty;
    logic [ByteW-1:0] target;
    logic             dual;
  } res_t;

endpackage

>>> sv/tree_relay_slew_limited_pwm_top.sv
// ----------------------------------------------------------------------------
// tree_relay_slew_limited_pwm_top: byte relay to two child ports with a
// slew-limited PWM setpoint
// Input register, combinational step logic, result register.
// ----------------------------------------------------------------------------
// Each input item (received byte, millisecond tick or PWM tick) is taken
// into an input register and applied to the relay state once the result
// register can take it; a result passes the input register and the result
// register before it can transfer. Items that give one result are accepted
// every cycle while m_axis_tready is high. A command or ramp-rate echo gives
// two output transfers (port 0, then port 1, the second with tlast) and so
// holds the result register for both transfers, during which one more input
// item is still taken into the input register.
// Configuration writes are taken every cycle and should be made while idle.
module tree_relay_slew_limited_pwm_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trsp_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [trsp_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  logic [trsp_pkg::CmdW-1:0]     s_axis_tuser,   // [1:0] cmd
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*trsp_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] tx_byte, [15:8] duty,
                                                        // [23:16] target_level
  output logic [1:0]                    m_axis_tuser,   // [0] tx_valid, [1] tx_port
  output logic                          m_axis_tlast
);
  import trsp_pkg::*;

  logic             in_v_q, in_v_d;
  logic [CmdW-1:0]  in_cmd_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_free;
  logic             advance;
  logic             s_xfer;
  res_t             step_res;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_v_q & out_free;
  assign s_axis_tready = ~in_v_q | advance;
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (s_xfer) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  trsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .cmd_i       (in_cmd_q),
    .byte_i      (in_byte_q),
    .res_o       (step_res)
  );

  trsp_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .res_i         (step_res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> sv/trsp_core.sv
// ----------------------------------------------------------------------------
// trsp_core: relay state and combinational step logic
// Holds phase, elapsed timer, setpoint, ramp rate and duty, plus the two timeout
// registers. Each advance applies one registered input item and presents
// its result record.
// ----------------------------------------------------------------------------
module trsp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [trsp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [trsp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            advance_i,
  input  logic [trsp_pkg::CmdW-1:0]       cmd_i,
  input  logic [trsp_pkg::ByteW-1:0]      byte_i,
  output trsp_pkg::res_t                  res_o
);
  import trsp_pkg::*;

  logic [ByteW-1:0]    msg_to_q;
  logic [ElapsedW-1:0] shutoff_q;
  phase_e              phase_q, phase_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [ByteW-1:0]    target_q, target_d;
  logic [ByteW-1:0]    slew_q, slew_d;
  logic [ByteW-1:0]    duty_q, duty_d;
  logic                child_q, child_d;

  logic [ElapsedW-1:0] elapsed_inc;
  logic [ByteW:0]      duty_up;
  logic [ByteW-1:0]    duty_dn;
  logic [ByteW-1:0]    duty_slew;

  // slew toward the setpoint, clamping at it
  always_comb begin
    duty_up = {1'b0, duty_q} + {1'b0, slew_q};
    duty_dn = (duty_q >= slew_q) ? (duty_q - slew_q) : '0;
    if (duty_q < target_q) begin
      duty_slew = (duty_up > {1'b0, target_q}) ? target_q : duty_up[ByteW-1:0];
    end else if (duty_q > target_q) begin
      duty_slew = (duty_dn < target_q) ? target_q : duty_dn;
    end else begin
      duty_slew = duty_q;
    end
  end

  assign elapsed_inc = (elapsed_q < ElapsedMax) ? (elapsed_q + 1'b1) : elapsed_q;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    target_d  = target_q;
    slew_d    = slew_q;
    duty_d    = duty_q;
    child_d   = child_q;
    res_o     = '0;

    case (cmd_i)
      CMD_BYTE: begin
        elapsed_d = '0;
        case (phase_q)
          PH_IDLE: begin
            if (byte_i == BCMD_ZERO) begin
              target_d = '0;
            end else if (byte_i == BCMD_SET) begin
              phase_d = PH_SETPOINT;
            end else if (byte_i == BCMD_RAMP) begin
              phase_d = PH_RAMP;
            end
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = byte_i;
            res_o.dual     = 1'b1;
          end
          PH_SETPOINT: begin
            target_d = byte_i;
            child_d  = 1'b0;
            phase_d  = PH_FORWARD;
          end
          PH_FORWARD: begin
            child_d        = ~child_q;
            res_o.tx_valid = 1'b1;
            res_o.tx_port  = child_q;
            res_o.tx_byte  = byte_i;
          end
          default: begin
            slew_d         = byte_i;
            phase_d        = PH_IDLE;
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = byte_i;
            res_o.dual     = 1'b1;
          end
        endcase
      end
      CMD_MS: begin
        elapsed_d = elapsed_inc;
        if (phase_q == PH_IDLE) begin
          if (elapsed_inc >= shutoff_q) begin
            target_d  = '0;
            elapsed_d = '0;
          end
        end else if (elapsed_inc >= {{(ElapsedW-ByteW){1'b0}}, msg_to_q}) begin
          phase_d   = PH_IDLE;
          elapsed_d = '0;
        end
      end
      CMD_PWM: begin
        duty_d = duty_slew;
      end
      default: begin
      end
    endcase

    res_o.duty   = duty_d;
    res_o.target = target_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_to_q  <= MsgTimeoutRst;
      shutoff_q <= ShutoffRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MSG_TIMEOUT: msg_to_q  <= cfg_data_i[ByteW-1:0];
        REG_SHUTOFF:     shutoff_q <= cfg_data_i[ElapsedW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      target_q  <= '0;
      slew_q    <= SlewRateRst;
      duty_q    <= '0;
      child_q   <= 1'b0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      target_q  <= target_d;
      slew_q    <= slew_d;
      duty_q    <= duty_d;
      child_q   <= child_d;
    end
  end

endmodule

>>> sv/trsp_out.sv
// ----------------------------------------------------------------------------
// trsp_out: result register and echo serializer
// Holds one item's result record and sends it as one or two transfers;
// an echo goes to port 0 first, then to port 1.
// ----------------------------------------------------------------------------
module trsp_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  trsp_pkg::res_t                res_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*trsp_pkg::ByteW-1:0]  m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  import trsp_pkg::*;

  logic res_v_q, res_v_d;
  logic sel_q, sel_d;
  res_t res_q;
  logic xfer;
  logic is_last;

  assign is_last = ~res_q.dual | sel_q;
  assign xfer    = res_v_q & m_axis_tready;
  assign free_o  = ~res_v_q | (xfer & is_last);

  always_comb begin
    res_v_d = res_v_q;
    sel_d   = sel_q;
    if (load_i) begin
      res_v_d = 1'b1;
      sel_d   = 1'b0;
    end else if (xfer) begin
      if (is_last) begin
        res_v_d = 1'b0;
      end else begin
        sel_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      res_v_q <= res_v_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tlast  = is_last;
  assign m_axis_tuser  = {(res_q.dual ? sel_q : res_q.tx_port), res_q.tx_valid};
  assign m_axis_tdata  = {res_q.target, res_q.duty, res_q.tx_byte};

endmodule
